// File: sv/mmu_pkg.sv
// Shared types and constants for the matrix multiply unit.
// No dependencies; every other file in this block imports it.
package mmu_pkg;

   // element and result widths
   localparam int ELEM_W = 16;
   localparam int PROD_W = 32;
   localparam int ACC_W  = 36;
   localparam int IDX_W  = 4;
   localparam int DIM_W  = 5;
   localparam int CSR_W  = 2;

   // configuration register indexes
   localparam logic [CSR_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_W-1:0] CSR_COLS_B    = 2'd2;

   // request function codes
   localparam logic FUNC_LOAD_B   = 1'b0;
   localparam logic FUNC_STREAM_A = 1'b1;

   typedef struct packed {
      logic                     func;
      logic signed [ELEM_W-1:0] element;
   } mmu_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        row_index;
      logic [IDX_W-1:0]        col_index;
      logic signed [ACC_W-1:0] product_value;
      logic                    last_of_row;
      logic                    last_of_matrix;
   } mmu_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear;      // zero all accumulators
      logic b_write;    // store request element into B memory
      logic a_load;     // capture request element as current A value
      logic issue;      // read B at address, run one lane through the MAC
      logic emit;       // this A element closes its row
      logic lane_last;  // lane is the last column of B
      logic mat_last;   // row is the last row of A
   } mmu_cmd_type;

endpackage

// File: sv/mmu_ctrl.sv
// Controller for the matrix multiply unit: configuration registers,
// position counters and the lane-issue state machine. Depends on mmu_pkg.
module mmu_ctrl #(
   parameter int MAX_DIM = 16,
   parameter int AW      = 8,
   parameter int LW      = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_func,
   input  logic                        csr_we,
   input  logic [mmu_pkg::CSR_W-1:0]   csr_index,
   input  logic [mmu_pkg::DIM_W-1:0]   csr_wdata,
   output mmu_pkg::mmu_cmd_type        cmd,
   output logic [AW-1:0]               addr,
   output logic [LW-1:0]               lane,
   output logic [mmu_pkg::IDX_W-1:0]   row_index
);
   import mmu_pkg::*;

   localparam int CW = (LW > DIM_W) ? LW : DIM_W;
   localparam int TW = (AW > 2 * DIM_W) ? AW : 2 * DIM_W;
   localparam int SW = AW + DIM_W;

   typedef enum logic {
      ST_IDLE,
      ST_MAC
   } state_type;

   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  rows_ff, rows_in;
   logic [DIM_W-1:0]  inner_ff, inner_in;
   logic [DIM_W-1:0]  cols_ff, cols_in;
   logic [LW-1:0]     lane_ff, lane_in;
   logic [LW-1:0]     col_pos_ff, col_pos_in;
   logic [LW-1:0]     row_pos_ff, row_pos_in;
   logic [AW-1:0]     col_base_ff, col_base_in;
   logic [AW-1:0]     b_pos_ff, b_pos_in;
   logic              emit_ff, emit_in;
   logic              mat_last_ff, mat_last_in;

   logic                accept;
   logic                restart;
   logic                lane_last;
   logic [2*DIM_W-1:0]  total;
   logic [DIM_W-1:0]    dim_clamped;

   // map a written dimension into 1..MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign accept      = start && (state_ff == ST_IDLE);
   assign restart     = csr_we && (csr_index == CSR_ROWS_A || csr_index == CSR_INNER_DIM
                                   || csr_index == CSR_COLS_B);
   assign total       = (2*DIM_W)'(inner_ff) * (2*DIM_W)'(cols_ff);
   assign lane_last   = CW'(lane_ff) == CW'(cols_ff) - CW'(1);
   assign dim_clamped = clamp_dim(csr_wdata);
   assign busy        = (state_ff != ST_IDLE);

   // drive commands to the datapath
   always_comb begin
      cmd.clear     = restart;
      cmd.b_write   = accept && (req_func == FUNC_LOAD_B);
      cmd.a_load    = accept && (req_func == FUNC_STREAM_A);
      cmd.issue     = (state_ff == ST_MAC);
      cmd.emit      = emit_ff;
      cmd.lane_last = lane_last;
      cmd.mat_last  = mat_last_ff;
      addr          = (state_ff == ST_MAC) ? AW'(SW'(col_base_ff) + SW'(lane_ff)) : b_pos_ff;
      lane          = lane_ff;
      row_index     = IDX_W'(row_pos_ff);
   end

   // next-state logic
   always_comb begin
      state_in    = state_ff;
      rows_in     = rows_ff;
      inner_in    = inner_ff;
      cols_in     = cols_ff;
      lane_in     = lane_ff;
      col_pos_in  = col_pos_ff;
      row_pos_in  = row_pos_ff;
      col_base_in = col_base_ff;
      b_pos_in    = b_pos_ff;
      emit_in     = emit_ff;
      mat_last_in = mat_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_LOAD_B) begin
               // advance B load position, wrap at inner_dim*cols_b
               if (TW'(b_pos_ff) == TW'(total) - TW'(1)) begin
                  b_pos_in = '0;
               end else begin
                  b_pos_in = b_pos_ff + AW'(1);
               end
            end else if (accept) begin
               state_in    = ST_MAC;
               lane_in     = '0;
               emit_in     = CW'(col_pos_ff) == CW'(inner_ff) - CW'(1);
               mat_last_in = CW'(row_pos_ff) == CW'(rows_ff) - CW'(1);
            end
         end
         ST_MAC: begin
            lane_in = lane_ff + LW'(1);
            if (lane_last) begin
               state_in = ST_IDLE;
               if (emit_ff) begin
                  col_pos_in  = '0;
                  col_base_in = '0;
                  row_pos_in  = mat_last_ff ? '0 : row_pos_ff + LW'(1);
               end else begin
                  col_pos_in  = col_pos_ff + LW'(1);
                  col_base_in = AW'(SW'(col_base_ff) + SW'(cols_ff));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register write: update dimension and restart positions
      if (restart) begin
         case (csr_index)
            CSR_ROWS_A:    rows_in  = dim_clamped;
            CSR_INNER_DIM: inner_in = dim_clamped;
            CSR_COLS_B:    cols_in  = dim_clamped;
            default:       rows_in  = rows_ff;
         endcase
         col_pos_in  = '0;
         row_pos_in  = '0;
         col_base_in = '0;
         b_pos_in    = '0;
      end
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rows_ff     <= DIM_W'(1);
         inner_ff    <= DIM_W'(1);
         cols_ff     <= DIM_W'(1);
         lane_ff     <= '0;
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         col_base_ff <= '0;
         b_pos_ff    <= '0;
         emit_ff     <= 1'b0;
         mat_last_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rows_ff     <= rows_in;
         inner_ff    <= inner_in;
         cols_ff     <= cols_in;
         lane_ff     <= lane_in;
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         col_base_ff <= col_base_in;
         b_pos_ff    <= b_pos_in;
         emit_ff     <= emit_in;
         mat_last_ff <= mat_last_in;
      end
   end

endmodule

// File: sv/mmu_datapath.sv
// Datapath for the matrix multiply unit: B memory, A register, multiply
// stage, row accumulators and the result register. Depends on mmu_pkg.
module mmu_datapath #(
   parameter int MAX_DIM = 16,
   parameter int AW      = 8,
   parameter int LW      = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mmu_pkg::mmu_cmd_type                cmd,
   input  logic [AW-1:0]                       addr,
   input  logic [LW-1:0]                       lane,
   input  logic [mmu_pkg::IDX_W-1:0]           row_index,
   input  logic signed [mmu_pkg::ELEM_W-1:0]   element,
   output logic                                rsp_valid,
   output mmu_pkg::mmu_rsp_type                rsp_data
);
   import mmu_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;

   logic signed [ELEM_W-1:0] b_mem [DEPTH];
   logic signed [ELEM_W-1:0] b_rd_ff;
   logic signed [ELEM_W-1:0] a_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff [MAX_DIM];
   logic signed [ACC_W-1:0]  sum;

   mmu_cmd_type              s1_cmd_ff, s2_cmd_ff;
   logic [LW-1:0]            s1_lane_ff, s2_lane_ff;
   logic [IDX_W-1:0]         s1_row_ff, s2_row_ff;
   logic                     rsp_valid_ff;
   mmu_rsp_type              rsp_ff;

   // B memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.b_write) begin
         b_mem[addr] <= element;
      end
      b_rd_ff <= b_mem[addr];
   end

   // hold A element for the whole lane pass; multiply stage
   always_ff @(posedge clock) begin
      if (cmd.a_load) begin
         a_ff <= element;
      end
      prod_ff    <= a_ff * b_rd_ff;
      s1_lane_ff <= lane;
      s1_row_ff  <= row_index;
      s2_lane_ff <= s1_lane_ff;
      s2_row_ff  <= s1_row_ff;
   end

   // stage control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_cmd_ff <= '0;
         s2_cmd_ff <= '0;
      end else begin
         s1_cmd_ff <= cmd;
         s2_cmd_ff <= s1_cmd_ff;
      end
   end

   assign sum = acc_ff[s2_lane_ff] + ACC_W'(prod_ff);

   // accumulate, or emit and clear at row end
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < MAX_DIM; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (s2_cmd_ff.issue) begin
         acc_ff[s2_lane_ff] <= s2_cmd_ff.emit ? '0 : sum;
      end
   end

   // result register, one cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_cmd_ff.issue && s2_cmd_ff.emit;
      end
      rsp_ff.row_index      <= s2_row_ff;
      rsp_ff.col_index      <= IDX_W'(s2_lane_ff);
      rsp_ff.product_value  <= sum;
      rsp_ff.last_of_row    <= s2_cmd_ff.lane_last;
      rsp_ff.last_of_matrix <= s2_cmd_ff.lane_last && s2_cmd_ff.mat_last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/matrix_multiply_unit.sv
// Matrix multiply unit: C = A * B with Q8.8 elements and exact Q20.16 sums.
// Top level; depends on mmu_pkg, mmu_ctrl and mmu_datapath.
//
// Usage: set rows_a, inner_dim and cols_b through the csr_ port (0 reads
// as 1, values above MAX_DIM as MAX_DIM); any write to one of them restarts
// the positions and clears the accumulators, B memory keeps its contents.
// Present a word on req_data with start high; it is taken when busy is low.
// func 0 words load B row-major and can follow back to back. func 1 words
// stream A row-major; each one runs cols_b lanes through the B memory read,
// multiplier and accumulator, one lane per cycle, and holds busy until its
// last lane has issued; the next word is taken once busy is low again. On
// the last A word of a row the unit strobes rsp_valid once per lane on
// consecutive cycles, one result word per cycle, each result passing the B
// read, product and result registers. The receiver cannot stall; each
// result is on rsp_data for exactly one cycle. Reset sets all dimensions to
// 1, clears positions and accumulators; B memory is not cleared and must be
// loaded before use.
module matrix_multiply_unit #(
   parameter int MAX_DIM = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  mmu_pkg::mmu_req_type       req_data,
   output logic                       rsp_valid,
   output mmu_pkg::mmu_rsp_type       rsp_data,
   input  logic                       csr_we,
   input  logic [mmu_pkg::CSR_W-1:0]  csr_index,
   input  logic [mmu_pkg::DIM_W-1:0]  csr_wdata
);
   import mmu_pkg::*;

   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
   localparam int LW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   mmu_cmd_type       cmd;
   logic [AW-1:0]     addr;
   logic [LW-1:0]     lane;
   logic [IDX_W-1:0]  row_index;

   mmu_ctrl #(
      .MAX_DIM (MAX_DIM),
      .AW      (AW),
      .LW      (LW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_func  (req_data.func),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .addr      (addr),
      .lane      (lane),
      .row_index (row_index)
   );

   mmu_datapath #(
      .MAX_DIM (MAX_DIM),
      .AW      (AW),
      .LW      (LW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .addr      (addr),
      .lane      (lane),
      .row_index (row_index),
      .element   (req_data.element),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/mmu_product_checker.sv
`timescale 1ns / 100ps
// Checker for the matrix multiply unit: watches the request, result and csr
// ports, predicts every result word and compares it. Depends on mmu_pkg.
module mmu_product_checker #(
   parameter int MAX_DIM = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  mmu_pkg::mmu_req_type       req_data,
   input  logic                       rsp_valid,
   input  mmu_pkg::mmu_rsp_type       rsp_data,
   input  logic                       csr_we,
   input  logic [mmu_pkg::CSR_W-1:0]  csr_index,
   input  logic [mmu_pkg::DIM_W-1:0]  csr_wdata,
   output int                         errors,
   output int                         pending,
   output int                         rows_eff,
   output int                         inner_eff,
   output int                         cols_eff
);
   import mmu_pkg::*;

   // predicted state of the unit
   logic signed [ELEM_W-1:0] b_matrix [MAX_DIM*MAX_DIM];
   logic signed [ACC_W-1:0]  row_sums [MAX_DIM];
   int b_pos, a_col, a_row;
   int n_rows, n_inner, n_cols;

   // results predicted but not yet seen, oldest first
   mmu_rsp_type expected_products [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic int fit_dim(input logic [DIM_W-1:0] v);
      if (v == '0)
         return 1;
      if (int'(v) > MAX_DIM)
         return MAX_DIM;
      return int'(v);
   endfunction

   task automatic restart_positions();
      for (int c = 0; c < MAX_DIM; c++)
         row_sums[c] = '0;
      b_pos = 0;
      a_col = 0;
      a_row = 0;
   endtask

   task automatic write_dim(input logic [CSR_W-1:0] idx, input logic [DIM_W-1:0] v);
      case (idx)
         CSR_ROWS_A:    n_rows  = fit_dim(v);
         CSR_INNER_DIM: n_inner = fit_dim(v);
         CSR_COLS_B:    n_cols  = fit_dim(v);
         default: ;
      endcase
      // any write to a real register restarts the product
      if (idx <= CSR_COLS_B)
         restart_positions();
   endtask

   // Apply one accepted word: store a B element, or run one A element
   // through all lanes and queue the row when it closes.
   task automatic multiply_step(input mmu_req_type w);
      int total;
      logic signed [PROD_W-1:0] prod;
      mmu_rsp_type r;
      total = n_inner * n_cols;
      if (w.func == FUNC_LOAD_B) begin
         if (b_pos >= total)
            b_pos = 0;
         b_matrix[b_pos] = w.element;
         b_pos++;
         if (b_pos >= total)
            b_pos = 0;
      end else begin
         if (a_col >= n_inner)
            a_col = 0;
         if (a_row >= n_rows)
            a_row = 0;
         for (int c = 0; c < n_cols; c++) begin
            prod = w.element * b_matrix[a_col*n_cols + c];
            row_sums[c] = row_sums[c] + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
         end
         a_col++;
         if (a_col >= n_inner) begin
            for (int c = 0; c < n_cols; c++) begin
               r.row_index      = a_row[IDX_W-1:0];
               r.col_index      = c[IDX_W-1:0];
               r.product_value  = row_sums[c];
               r.last_of_row    = (c == n_cols - 1);
               r.last_of_matrix = r.last_of_row && (a_row == n_rows - 1);
               expected_products.push_back(r);
               row_sums[c] = '0;
            end
            a_col = 0;
            a_row++;
            if (a_row >= n_rows)
               a_row = 0;
         end
      end
   endtask

   task automatic check_product(input mmu_rsp_type got);
      mmu_rsp_type want;
      if (expected_products.size() == 0) begin
         report_mismatch("result word with none expected",
                         64'({got.row_index, got.col_index}), 64'(0));
         return;
      end
      want = expected_products.pop_front();
      if (got.row_index !== want.row_index)
         report_mismatch("row_index", 64'(got.row_index), 64'(want.row_index));
      if (got.col_index !== want.col_index)
         report_mismatch("col_index", 64'(got.col_index), 64'(want.col_index));
      if (got.product_value !== want.product_value)
         report_mismatch("product_value", 64'(got.product_value),
                         64'(want.product_value));
      if (got.last_of_row !== want.last_of_row)
         report_mismatch("last_of_row", 64'(got.last_of_row), 64'(want.last_of_row));
      if (got.last_of_matrix !== want.last_of_matrix)
         report_mismatch("last_of_matrix", 64'(got.last_of_matrix),
                         64'(want.last_of_matrix));
   endtask

   // Sample every port at the edge; results come first, then csr, then requests.
   always @(posedge clock) begin
      if (reset) begin
         errors  = 0;
         n_rows  = 1;
         n_inner = 1;
         n_cols  = 1;
         restart_positions();
         expected_products.delete();
      end else begin
         if (rsp_valid)
            check_product(rsp_data);
         if (csr_we)
            write_dim(csr_index, csr_wdata);
         if (start && !busy)
            multiply_step(req_data);
      end
      pending   <= expected_products.size();
      rows_eff  <= n_rows;
      inner_eff <= n_inner;
      cols_eff  <= n_cols;
   end

endmodule

// File: tb/matrix_multiply_unit_test.sv
`timescale 1ns / 100ps
// Top of the matrix multiply unit testbench: clock, reset, stimulus and verdict.
// Depends on mmu_pkg, matrix_multiply_unit and mmu_product_checker.
module matrix_multiply_unit_test;
   import mmu_pkg::*;

   localparam int MAX_DIM        = 16;
   localparam int RANDOM_WORDS   = 175;
   localparam int SETTLE_CYCLES  = 24;
   localparam int QUIET_LIMIT    = 2000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   mmu_req_type        req_data = '0;
   logic               rsp_valid;
   mmu_rsp_type        rsp_data;
   logic               csr_we = 1'b0;
   logic [CSR_W-1:0]   csr_index = CSR_ROWS_A;
   logic [DIM_W-1:0]   csr_wdata = '0;

   int errors, pending, rows_eff, inner_eff, cols_eff;
   int words_sent = 0;
   int quiet_cycles = 0;
   int b_covered = 0;
   bit no_gaps = 1'b0;

   matrix_multiply_unit #(.MAX_DIM(MAX_DIM)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   mmu_product_checker #(.MAX_DIM(MAX_DIM)) product_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending), .rows_eff(rows_eff),
      .inner_eff(inner_eff), .cols_eff(cols_eff)
   );

   always #6 clock = ~clock;

   // End the run when nothing moves on any port for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we)
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic logic signed [ELEM_W-1:0] rand_element();
      int u;
      int r;
      r = $urandom_range(0, 9);
      u = $urandom_range(0, 65535);
      // favor the corners now and then
      if (r == 0)
         return (u[0]) ? 16'sh8000 : 16'sh7fff;
      if (r == 1)
         return (u[0]) ? 16'sh0000 : 16'shffff;
      return u[ELEM_W-1:0];
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 10)
         v = MAX_DIM;
      else if (r < 22)
         v = 1;
      else if (r < 30)
         v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_DIM + 1, 31);
      else
         v = $urandom_range(2, 6);
      return v[DIM_W-1:0];
   endfunction

   // Present one word and hold it until the unit takes it
   task automatic send_word(input logic func, input logic signed [ELEM_W-1:0] value);
      mmu_req_type w;
      w.func = func;
      w.element = value;
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   // Drop start for a random gap, mostly none or short, sometimes long
   task automatic pause_sender();
      int r;
      int n;
      logic [31:0] junk;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 45)
         n = 0;
      else if (r < 90)
         n = $urandom_range(1, 3);
      else
         n = $urandom_range(8, 40);
      if (n > 0) begin
         junk = $urandom;
         start <= 1'b0;
         req_data <= junk[$bits(mmu_req_type)-1:0];
         repeat (n) @(posedge clock);
      end
   endtask

   // Hold off until every expected word is out and the last pass has drained
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the registers picked by mask while idle, then let the checker catch up
   task automatic write_dims(input int mask, input logic [DIM_W-1:0] rows_v,
                             input logic [DIM_W-1:0] inner_v,
                             input logic [DIM_W-1:0] cols_v);
      wait_idle();
      if (mask[0]) begin
         csr_we <= 1'b1;
         csr_index <= CSR_ROWS_A;
         csr_wdata <= rows_v;
         @(posedge clock);
      end
      if (mask[1]) begin
         csr_we <= 1'b1;
         csr_index <= CSR_INNER_DIM;
         csr_wdata <= inner_v;
         @(posedge clock);
      end
      if (mask[2]) begin
         csr_we <= 1'b1;
         csr_index <= CSR_COLS_B;
         csr_wdata <= cols_v;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int directed_words;
      int total;
      int nb;
      int na;
      int rows_run;
      int r;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 2x2 times 2x3 with corner values; B overruns its end by two words
      write_dims(7, 5'd2, 5'd2, 5'd3);
      send_word(FUNC_LOAD_B, 16'sh7fff);
      send_word(FUNC_LOAD_B, 16'sh8000);
      send_word(FUNC_LOAD_B, 16'sh0000);
      send_word(FUNC_LOAD_B, 16'shffff);
      send_word(FUNC_LOAD_B, 16'sh0001);
      send_word(FUNC_LOAD_B, 16'sh0100);
      send_word(FUNC_LOAD_B, 16'sh8000);
      send_word(FUNC_LOAD_B, 16'sh7fff);
      b_covered = 6;
      // one full product, then a row of the next one with the same B
      send_word(FUNC_STREAM_A, 16'sh8000);
      send_word(FUNC_STREAM_A, 16'sh8000);
      send_word(FUNC_STREAM_A, 16'sh7fff);
      send_word(FUNC_STREAM_A, 16'shffff);
      send_word(FUNC_STREAM_A, 16'sh0001);
      send_word(FUNC_STREAM_A, 16'sh8000);

      // out-of-range settings: rows saturate to the maximum, zeros read as one
      write_dims(7, 5'd31, 5'd0, 5'd0);
      send_word(FUNC_STREAM_A, 16'sh7fff);
      send_word(FUNC_STREAM_A, 16'sh8000);
      send_word(FUNC_STREAM_A, 16'sh0100);
      directed_words = words_sent;

      // Random phases: reconfigure, load B when needed, then stream A rows
      while (words_sent < directed_words + RANDOM_WORDS) begin
         no_gaps = 1'b0;
         write_dims($urandom_range(1, 7), pick_dim(), pick_dim(), pick_dim());
         total = inner_eff * cols_eff;
         no_gaps = ($urandom_range(0, 4) == 0);

         // only skip or cut the B load when every entry it reads is written
         r = $urandom_range(0, 99);
         if (b_covered < total || r < 30)
            nb = total;
         else if (r < 55)
            nb = 0;
         else if (r < 80)
            nb = (total > 1) ? $urandom_range(1, total - 1) : 1;
         else
            nb = total;
         if ($urandom_range(0, 4) == 0)
            nb += $urandom_range(1, 4);
         for (int i = 0; i < nb; i++) begin
            send_word(FUNC_LOAD_B, rand_element());
            pause_sender();
         end
         if (nb > b_covered)
            b_covered = (nb > total) ? total : nb;

         rows_run = $urandom_range(1, rows_eff + 1);
         if (rows_run > 4)
            rows_run = 4;
         na = rows_run * inner_eff;
         // now and then break off in the middle of a row
         if ($urandom_range(0, 9) == 0 && inner_eff > 1)
            na -= $urandom_range(1, inner_eff - 1);
         for (int i = 0; i < na; i++) begin
            if ($urandom_range(0, 19) == 0) begin
               send_word(FUNC_LOAD_B, rand_element());
               pause_sender();
            end
            send_word(FUNC_STREAM_A, rand_element());
            pause_sender();
         end
      end

      wait_idle();
      if (errors == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
